### hdl/lbr_pkg.sv
// lbr_pkg: types and constants shared by the lcg48 bounded random block
// beat structs, control/status structs, state enum and generator constants
// no dependencies
package lbr_pkg;

   localparam logic [34:0] LCG_MULT = 35'h5_DEEC_E66D;
   localparam logic [47:0] LCG_INC = 48'hB;
   localparam int unsigned DIV_STEPS = 31;

   localparam logic CMD_SEED = 1'b0;
   localparam logic CMD_DRAW = 1'b1;

   localparam logic [1:0] REG_BOUNDED_MODE = 2'd0;
   localparam logic [1:0] REG_MIN_BOUND = 2'd1;
   localparam logic [1:0] REG_MAX_BOUND = 2'd2;

   typedef struct packed {
      logic command;
      logic signed [63:0] seed_value;
   } req_beat_type;

   typedef struct packed {
      logic [31:0] random_value;
      logic span_error;
   } rsp_beat_type;

   typedef enum logic [1:0] {
      OUT_RAW,
      OUT_BOUNDED,
      OUT_ERROR
   } out_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADV0,
      ST_ADV1,
      ST_ADV2,
      ST_ADV3,
      ST_POW,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_DIV_CHECK,
      ST_OUT
   } lbr_state_type;

   typedef struct packed {
      logic load_seed;
      logic mul_first;
      logic mul_acc;
      logic mul_prod;
      logic [1:0] mul_idx;
      logic mul_commit;
      logic pow_load;
      logic div_init;
      logic div_step;
      logic val_from_rem;
      logic out_load;
      out_sel_type out_sel;
   } lbr_cmd_type;

   typedef struct packed {
      logic bounded;
      logic span_err;
      logic span_pow2;
      logic reject;
   } lbr_status_type;

endpackage

### hdl/lcg48_bounded_random.sv
// lcg48_bounded_random: top level of the 48-bit lcg with bounded draws
// instantiates lbr_ctrl and lbr_dp, depends on lbr_pkg
//
// usage:
//   req channel (req_valid/req_stall/req_data) carries one command beat.
//   command seed loads seed_value[47:0] xor the multiplier into the state and
//   gives no rsp beat; it is taken in the accept cycle. command draw gives
//   exactly one rsp beat (random_value, span_error) on rsp_valid/rsp_stall.
//   csr port: csr_wr_en writes csr_wdata to register csr_index
//   (0 bounded_mode, 1 min_bound, 2 max_bound); write only while idle.
//   steps of a draw: unbounded draws run the split multiply (ST_ADV0 to ST_ADV3);
//     a bad span goes straight to the output; a power-of-two span adds a scale
//     step; other spans add setup, a one-bit-per-cycle remainder of the 31-bit
//     draw and a check, and each rejected draw repeats multiply and remainder.
//   one command is worked at a time; req_stall is high while a draw runs,
//   so the next command can be taken in the cycle in which rsp_valid rises.
//   the rsp beat sits in an output register, so a new command is taken while
//   a result waits; a stalled rsp holds and a following draw waits at its end.
//   synchronous reset clears state, config registers, generator state and rsp_valid.
module lcg48_bounded_random
   import lbr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_beat_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_beat_type rsp_data,
   input  logic csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_wdata
);

   lbr_cmd_type cmd;
   lbr_status_type status;

   lbr_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_data.command),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   lbr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

### hdl/lbr_dp.sv
// lbr_dp: datapath with generator state, config registers, split multiplier,
// power-of-two scaler, bit-serial remainder unit and result register
// depends on lbr_pkg
module lbr_dp
   import lbr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [31:0] csr_wdata,
   input  req_beat_type req_data,
   input  lbr_cmd_type cmd,
   output lbr_status_type status,
   output rsp_beat_type rsp_data
);

   logic bounded_ff;
   logic [31:0] min_ff;
   logic [31:0] max_ff;
   logic [47:0] lcg_ff;
   logic [47:0] acc_ff;
   logic [47:0] prod_ff;
   logic [31:0] val_ff;
   logic [31:0] rem_ff;
   logic [30:0] dvd_ff;
   rsp_beat_type rsp_ff;

   logic [32:0] span_wide;
   logic [31:0] span;
   logic [30:0] draw31;
   logic [15:0] chunk;
   logic [50:0] prod_full;
   logic [47:0] prod_in;
   logic [62:0] pow_prod;
   logic [32:0] rem_shift;
   logic [32:0] accept_sum;
   rsp_beat_type rsp_in;

   assign span_wide = {1'b0, max_ff} - {1'b0, min_ff} + 33'd1;
   assign span = span_wide[31:0];
   assign draw31 = lcg_ff[47:17];

   assign status.bounded = bounded_ff;
   assign status.span_err = (span == 32'd0) || (span > 32'h8000_0000);
   assign status.span_pow2 = ((span & (span - 32'd1)) == 32'd0);
   assign accept_sum = {2'b0, draw31} - {1'b0, rem_ff} + {1'b0, span} - 33'd1;
   assign status.reject = (accept_sum > 33'h0_7FFF_FFFF);

   // one 16-bit slice of the state per step
   always_comb begin
      case (cmd.mul_idx)
         2'd0: chunk = lcg_ff[15:0];
         2'd1: chunk = lcg_ff[31:16];
         2'd2: chunk = lcg_ff[47:32];
         default: chunk = 16'd0;
      endcase
      prod_full = 51'(chunk) * 51'(LCG_MULT);
      case (cmd.mul_idx)
         2'd0: prod_in = prod_full[47:0];
         2'd1: prod_in = {prod_full[31:0], 16'd0};
         2'd2: prod_in = {prod_full[15:0], 32'd0};
         default: prod_in = 48'd0;
      endcase
   end

   assign pow_prod = 63'(span) * 63'(draw31);
   assign rem_shift = {rem_ff, dvd_ff[30]};

   always_comb begin
      case (cmd.out_sel)
         OUT_RAW: begin
            rsp_in.random_value = lcg_ff[47:16];
            rsp_in.span_error = 1'b0;
         end
         OUT_BOUNDED: begin
            rsp_in.random_value = val_ff + min_ff;
            rsp_in.span_error = 1'b0;
         end
         OUT_ERROR: begin
            rsp_in.random_value = 32'd0;
            rsp_in.span_error = 1'b1;
         end
         default: begin
            rsp_in.random_value = 32'd0;
            rsp_in.span_error = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bounded_ff <= 1'b0;
         min_ff <= 32'd0;
         max_ff <= 32'd0;
         lcg_ff <= 48'd0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_BOUNDED_MODE: bounded_ff <= csr_wdata[0];
               REG_MIN_BOUND: min_ff <= csr_wdata;
               REG_MAX_BOUND: max_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load_seed) begin
            lcg_ff <= req_data.seed_value[47:0] ^ 48'(LCG_MULT);
         end else if (cmd.mul_commit) begin
            lcg_ff <= acc_ff + prod_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_first) begin
         acc_ff <= LCG_INC;
      end else if (cmd.mul_acc) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.mul_prod) begin
         prod_ff <= prod_in;
      end
      if (cmd.pow_load) begin
         val_ff <= pow_prod[62:31];
      end else if (cmd.val_from_rem) begin
         val_ff <= rem_ff;
      end
      if (cmd.div_init) begin
         rem_ff <= 32'd0;
         dvd_ff <= draw31;
      end else if (cmd.div_step) begin
         if (rem_shift >= {1'b0, span}) begin
            rem_ff <= 32'(rem_shift - {1'b0, span});
         end else begin
            rem_ff <= rem_shift[31:0];
         end
         dvd_ff <= {dvd_ff[29:0], 1'b0};
      end
      if (cmd.out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

### hdl/lbr_ctrl.sv
// lbr_ctrl: controller state machine sequencing seed load, state advance,
// scaling or remainder with rejection, and the result handshake
// depends on lbr_pkg
module lbr_ctrl
   import lbr_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_command,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  lbr_status_type status,
   output lbr_cmd_type cmd
);

   lbr_state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= 5'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall = (state_ff != ST_IDLE);
      cmd = '0;
      if (!status.bounded) begin
         cmd.out_sel = OUT_RAW;
      end else if (status.span_err) begin
         cmd.out_sel = OUT_ERROR;
      end else begin
         cmd.out_sel = OUT_BOUNDED;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_SEED) begin
                  cmd.load_seed = 1'b1;
               end else if (status.bounded && status.span_err) begin
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_ADV0;
               end
            end
         end
         ST_ADV0: begin
            cmd.mul_first = 1'b1;
            cmd.mul_prod = 1'b1;
            cmd.mul_idx = 2'd0;
            state_in = ST_ADV1;
         end
         ST_ADV1: begin
            cmd.mul_acc = 1'b1;
            cmd.mul_prod = 1'b1;
            cmd.mul_idx = 2'd1;
            state_in = ST_ADV2;
         end
         ST_ADV2: begin
            cmd.mul_acc = 1'b1;
            cmd.mul_prod = 1'b1;
            cmd.mul_idx = 2'd2;
            state_in = ST_ADV3;
         end
         ST_ADV3: begin
            cmd.mul_commit = 1'b1;
            if (!status.bounded) begin
               state_in = ST_OUT;
            end else if (status.span_pow2) begin
               state_in = ST_POW;
            end else begin
               state_in = ST_DIV_INIT;
            end
         end
         ST_POW: begin
            cmd.pow_load = 1'b1;
            state_in = ST_OUT;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            cnt_in = 5'd0;
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(DIV_STEPS - 1)) begin
               state_in = ST_DIV_CHECK;
            end
         end
         ST_DIV_CHECK: begin
            if (status.reject) begin
               state_in = ST_ADV0;
            end else begin
               cmd.val_from_rem = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
